// File: sv/rrva_pkg.sv
// shared constants, types and frame byte function for the round-robin voice allocator
package rrva_pkg;

    localparam int VOICE_COUNT = 3;
    localparam int SLOT_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int TRACK_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 8;
    localparam int BIDX_W      = $clog2(FRAME_BYTES);

    localparam logic [BYTE_W-1:0] FRAME_SOM1 = 8'hF0;
    localparam logic [BYTE_W-1:0] FRAME_SOM2 = 8'hAA;
    localparam logic [BYTE_W-1:0] FRAME_LEN  = 8'h08;
    localparam logic [BYTE_W-1:0] FRAME_CMD  = 8'h03;
    localparam logic [BYTE_W-1:0] CODE_PLAY  = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_STOP  = 8'h04;
    localparam logic [BYTE_W-1:0] FRAME_EOM  = 8'h55;

    localparam logic [BIDX_W-1:0] BIDX_SOM1 = BIDX_W'(0);
    localparam logic [BIDX_W-1:0] BIDX_SOM2 = BIDX_W'(1);
    localparam logic [BIDX_W-1:0] BIDX_LEN  = BIDX_W'(2);
    localparam logic [BIDX_W-1:0] BIDX_CMD  = BIDX_W'(3);
    localparam logic [BIDX_W-1:0] BIDX_CODE = BIDX_W'(4);
    localparam logic [BIDX_W-1:0] BIDX_TRLO = BIDX_W'(5);
    localparam logic [BIDX_W-1:0] BIDX_TRHI = BIDX_W'(6);
    localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(FRAME_BYTES - 1);

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [TRACK_W-1:0] track_t;
    typedef logic [BIDX_W-1:0]  byte_idx_t;

    // controller to datapath
    typedef struct packed {
        logic capture;       // latch the pressed track
        logic clear_match;   // free the slot holding the pressed track, load its stop frame
        logic load_steal;    // load stop frame for the track under the pointer
        logic load_play;     // write slot, advance pointer, load play frame
        logic byte_step;     // one frame byte taken
    } rrva_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_zero;       // offered track is the free marker
        logic match_hit;     // pressed track already holds a slot
        logic victim_busy;   // slot under the pointer is occupied
        logic byte_last;     // current byte closes its frame
        logic run_final;     // current frame closes the run
    } rrva_stat_t;

    function automatic logic [BYTE_W-1:0] frame_byte_at(
        input logic [BYTE_W-1:0] code,
        input track_t            track,
        input byte_idx_t         idx
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            BIDX_SOM1: b = FRAME_SOM1;
            BIDX_SOM2: b = FRAME_SOM2;
            BIDX_LEN:  b = FRAME_LEN;
            BIDX_CMD:  b = FRAME_CMD;
            BIDX_CODE: b = code;
            BIDX_TRLO: b = track[BYTE_W-1:0];
            BIDX_TRHI: b = track[TRACK_W-1:BYTE_W];
            default:   b = FRAME_EOM;
        endcase
        return b;
    endfunction

endpackage

// File: sv/rrva_ctrl.sv
// controller state machine: sequences lookup, steal, play and frame byte output
module rrva_ctrl
    import rrva_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  rrva_stat_t stat,
    output rrva_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_CHECK,
        S_PLAY,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !stat.in_zero)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.match_hit)
                begin
                    cmd.clear_match = 1'b1;
                    ret_next        = S_CHECK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.victim_busy)
                begin
                    cmd.load_steal = 1'b1;
                    ret_next       = S_PLAY;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_PLAY;
                end
            end
            S_PLAY:
            begin
                cmd.load_play = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.byte_step = 1'b1;
                    if (stat.byte_last)
                        state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // intake and output never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("intake open while a frame byte is offered");

    // the closing byte of the run reopens intake
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && stat.byte_last && stat.run_final) |=> in_ready)
        else $error("intake not reopened after the last byte");

    // the play frame always ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_play |=> (out_valid && stat.run_final))
        else $error("play frame not marked final");

endmodule

// File: sv/rrva_dpath.sv
// datapath: voice slot table, round-robin pointer and frame byte generator
module rrva_dpath
    import rrva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  track_t            track_number,
    input  rrva_cmd_t         cmd,
    output rrva_stat_t        stat,
    output logic [BYTE_W-1:0] frame_byte,
    output logic              last_byte
);

    track_t            slots_reg [VOICE_COUNT];
    track_t            slots_next[VOICE_COUNT];
    track_t            track_reg, track_next;
    slot_idx_t         ptr_reg, ptr_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    track_t            ftrack_reg, ftrack_next;
    logic              final_reg, final_next;
    byte_idx_t         idx_reg, idx_next;

    logic      match_hit;
    slot_idx_t match_idx;
    track_t    victim;

    // first slot holding the pressed track; lowest index wins
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (slots_reg[i] == track_reg)
            begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
    end

    assign victim = slots_reg[ptr_reg];

    always_comb
    begin
        slots_next  = slots_reg;
        track_next  = track_reg;
        ptr_next    = ptr_reg;
        code_next   = code_reg;
        ftrack_next = ftrack_reg;
        final_next  = final_reg;
        idx_next    = idx_reg;

        if (cmd.capture)
            track_next = track_number;

        if (cmd.clear_match)
        begin
            slots_next[match_idx] = '0;
            code_next             = CODE_STOP;
            ftrack_next           = track_reg;
            final_next            = 1'b0;
            idx_next              = '0;
        end

        if (cmd.load_steal)
        begin
            code_next   = CODE_STOP;
            ftrack_next = victim;
            final_next  = 1'b0;
            idx_next    = '0;
        end

        if (cmd.load_play)
        begin
            slots_next[ptr_reg] = track_reg;
            ptr_next    = (ptr_reg == SLOT_W'(VOICE_COUNT - 1)) ? '0 : ptr_reg + 1'b1;
            code_next   = CODE_PLAY;
            ftrack_next = track_reg;
            final_next  = 1'b1;
            idx_next    = '0;
        end

        if (cmd.byte_step)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
                slots_reg[i] <= '0;
            ptr_reg   <= '0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            slots_reg <= slots_next;
            ptr_reg   <= ptr_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        track_reg  <= track_next;
        code_reg   <= code_next;
        ftrack_reg <= ftrack_next;
    end

    assign stat.in_zero     = (track_number == '0);
    assign stat.match_hit   = match_hit;
    assign stat.victim_busy = (victim != '0);
    assign stat.byte_last   = (idx_reg == BIDX_LAST);
    assign stat.run_final   = final_reg;

    assign frame_byte = frame_byte_at(code_reg, ftrack_reg, idx_reg);
    assign last_byte  = final_reg && (idx_reg == BIDX_LAST);

    // pointer stays inside the slot table
    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= SLOT_W'(VOICE_COUNT - 1))
        else $error("round-robin pointer out of range");

    // a play leaves the pressed track in the slot the pointer named
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_play |=> (slots_reg[$past(ptr_reg)] == $past(track_reg)))
        else $error("play did not store the track");

endmodule

// File: sv/round_robin_voice_allocator.sv
// top level of the round-robin voice allocator with voice stealing
//
// Each accepted press names a track (1..65535); a press of track 0 is taken
// and dropped with no output. The block holds VOICE_COUNT voice slots and a
// round-robin pointer. A press of a track already playing first gives a stop
// frame for it and frees that slot; if the slot under the pointer is then
// occupied its track is stolen with a second stop frame; finally the track is
// written to that slot, a play frame follows and the pointer advances. Frames
// are eight bytes, F0 AA 08 03 code trackLo trackHi 55 (code 01 play, 04 stop),
// sent one byte per transaction on the output channel, with last_byte high on
// the final byte of the press's run (8, 16 or 24 bytes). The frame bytes are
// produced by a byte counter stepping once per output transaction. Besides its
// bytes, a press passes through lookup, steal check, slot update and the idle
// state that takes the next press; a dropped zero press only through idle.
// One press is handled at a time: in_ready is high only while no run is in
// progress. The slot table resets to all free and needs no clearing pass.
module round_robin_voice_allocator
    import rrva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TRACK_W-1:0] track_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] frame_byte,
    output logic              last_byte
);

    // command and status between sequencer and slot datapath
    rrva_cmd_t  cmd;
    rrva_stat_t stat;

    rrva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrva_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .track_number (track_number),
        .cmd          (cmd),
        .stat         (stat),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte)
    );

endmodule
